// ===== hdl/vsc_pkg.sv =====
`timescale 1ns / 1ps

package vsc_pkg;

  // Key storage and alphabet constants.
  localparam int KEY_MAX      = 32;
  localparam int KEY_POS_W    = $clog2(KEY_MAX);
  localparam int KEY_LEN_W    = 6;
  localparam int LETTERS      = 26;
  localparam logic [7:0] CHAR_A = 8'h41;

  // Depth of the queue between the front and the back end.
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCOUNT_W = $clog2(QDEPTH + 1);

  // Configuration port geometry.
  localparam int APB_ADDR_W = 6;
  localparam int APB_DATA_W = 64;

  // Register map, one 64-bit slot per register.
  typedef enum logic [2:0] {
    REG_CIPHER_MODE = 3'd0,
    REG_KEY_LENGTH  = 3'd1,
    REG_KEY_BYTES_A = 3'd2,
    REG_KEY_BYTES_B = 3'd3,
    REG_KEY_BYTES_C = 3'd4,
    REG_KEY_BYTES_D = 3'd5
  } vsc_reg_e;

  // Configuration as seen by the front end.
  typedef struct packed {
    logic                         mode;
    logic [KEY_LEN_W-1:0]         key_length;
    logic [KEY_MAX-1:0][7:0]      key_bytes;
  } vsc_cfg_t;

  // One classified transaction, handed from the front to the back end.
  typedef struct packed {
    logic [7:0]           text_byte;
    logic                 last;
    logic                 err;
    logic                 letter;
    logic                 mode;
    logic [4:0]           plain_idx;
    logic [4:0]           shift;
  } vsc_item_t;

  function automatic logic vsc_is_letter(input logic [7:0] b);
    vsc_is_letter = ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
  endfunction

  function automatic logic [7:0] vsc_fold_upper(input logic [7:0] b);
    vsc_fold_upper = ((b >= 8'h61) && (b <= 8'h7A)) ? (b - 8'h20) : b;
  endfunction

endpackage

// ===== hdl/vsc_front.sv =====
`timescale 1ns / 1ps

module vsc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         text_byte_i,
  input  logic               text_last_i,
  input  vsc_pkg::vsc_cfg_t  cfg_i,
  input  logic               full_i,
  output logic               push_o,
  output vsc_pkg::vsc_item_t push_item_o
);
  import vsc_pkg::*;

  logic                 accept;
  logic                 key_bad;
  logic                 letter;
  logic [KEY_POS_W-1:0] pos_sel;
  logic [KEY_LEN_W-1:0] pos_inc;
  logic [KEY_POS_W-1:0] pos_next;
  logic [7:0]           key_letter;
  logic [7:0]           shift_full;
  logic [7:0]           plain_full;
  logic [KEY_POS_W-1:0] key_pos_q;
  logic [KEY_POS_W-1:0] key_pos_d;

  // A transaction is taken whenever the queue has room.
  assign accept     = in_valid_i & ~full_i;
  assign in_stall_o = full_i;

  // The key is unusable if it is empty, too long, or holds a non-letter in use.
  always_comb begin
    key_bad = (cfg_i.key_length == '0) || (cfg_i.key_length > KEY_LEN_W'(KEY_MAX));
    for (int i = 0; i < KEY_MAX; i++) begin
      if ((KEY_LEN_W'(i) < cfg_i.key_length) && !vsc_is_letter(cfg_i.key_bytes[i])) begin
        key_bad = 1'b1;
      end
    end
  end

  // A position left over from a longer key restarts at the first letter.
  assign pos_sel    = ({1'b0, key_pos_q} < cfg_i.key_length) ? key_pos_q : '0;
  assign key_letter = cfg_i.key_bytes[pos_sel];
  assign shift_full = vsc_fold_upper(key_letter) - CHAR_A;
  assign plain_full = vsc_fold_upper(text_byte_i) - CHAR_A;
  assign letter     = vsc_is_letter(text_byte_i);

  // Advance with wrap at the key length.
  assign pos_inc  = {1'b0, pos_sel} + KEY_LEN_W'(1);
  assign pos_next = (pos_inc >= cfg_i.key_length) ? '0 : pos_inc[KEY_POS_W-1:0];

  always_comb begin
    key_pos_d = key_pos_q;
    if (accept) begin
      if (!key_bad && letter) begin
        key_pos_d = pos_next;
      end
      if (text_last_i) begin
        key_pos_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_pos_q <= '0;
    end else begin
      key_pos_q <= key_pos_d;
    end
  end

  // Classified transaction for the queue.
  assign push_o                  = accept;
  assign push_item_o.text_byte   = text_byte_i;
  assign push_item_o.last        = text_last_i;
  assign push_item_o.err         = key_bad;
  assign push_item_o.letter      = letter;
  assign push_item_o.mode        = cfg_i.mode;
  assign push_item_o.plain_idx   = plain_full[4:0];
  assign push_item_o.shift       = shift_full[4:0];

  // A message boundary always restarts the key.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && text_last_i) |=> (key_pos_q == '0))
    else $error("key position not cleared after last byte");

endmodule

// ===== hdl/vsc_queue.sv =====
`timescale 1ns / 1ps

module vsc_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  vsc_pkg::vsc_item_t push_item_i,
  input  logic               pop_i,
  output vsc_pkg::vsc_item_t pop_item_o,
  output logic               full_o,
  output logic               empty_o
);
  import vsc_pkg::*;

  vsc_item_t             slots_q [QDEPTH];
  logic [QPTR_W-1:0]     wr_ptr_q;
  logic [QPTR_W-1:0]     rd_ptr_q;
  logic [QCOUNT_W-1:0]   count_q;

  assign full_o     = (count_q == QCOUNT_W'(QDEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_item_o = slots_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_item_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QCOUNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QCOUNT_W'(1);
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCOUNT_W'(QDEPTH))
    else $error("queue count out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o) && !(pop_i && empty_o))
    else $error("queue overflow or underflow");

endmodule

// ===== hdl/vsc_back.sv =====
`timescale 1ns / 1ps

module vsc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  vsc_pkg::vsc_item_t item_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         cipher_byte_o,
  output logic               cipher_last_o,
  output logic               key_error_o
);
  import vsc_pkg::*;

  logic       out_valid_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic       err_q;
  logic [5:0] sum;
  logic [5:0] rem;
  logic [7:0] result;

  // Take the next entry whenever the output register is free or draining.
  assign pop_o = ~empty_i & (~out_valid_q | ~out_stall_i);

  // Shift modulo the alphabet: add the shift (mode 0) or 26 minus it (mode 1), then subtract 26 at most once.
  always_comb begin
    if (item_i.mode) begin
      sum = {1'b0, item_i.plain_idx} + 6'(LETTERS) - {1'b0, item_i.shift};
    end else begin
      sum = {1'b0, item_i.plain_idx} + {1'b0, item_i.shift};
    end
    rem = (sum >= 6'(LETTERS)) ? (sum - 6'(LETTERS)) : sum;
    if (item_i.err) begin
      result = '0;
    end else if (item_i.letter) begin
      result = CHAR_A + {2'b00, rem};
    end else begin
      result = item_i.text_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      byte_q <= result;
      last_q <= item_i.last;
      err_q  <= item_i.err;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cipher_byte_o = byte_q;
  assign cipher_last_o = last_q;
  assign key_error_o   = err_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && err_q) |-> (byte_q == '0))
    else $error("error result carries a nonzero byte");

endmodule

// ===== hdl/vigenere_stream_cipher.sv =====
`timescale 1ns / 1ps

// Vigenere stream cipher, one ASCII byte per transaction.
// Input channel: in_valid_i with text_byte_i and text_last_i; the block drives
// in_stall_o. Output channel: out_valid_o with cipher_byte_o, cipher_last_o and
// key_error_o; the receiver drives out_stall_i. A transaction moves at a clock
// edge with valid high and stall low.
// Letters are folded to upper case and shifted by the next key letter; other
// bytes pass unchanged. The key restarts after a byte marked last.
// Configuration goes through the APB port, one 64-bit register every 8 bytes:
// mode, key length, then four words of key bytes. Write only while idle.
// With a bad key, every byte comes out as zero with key_error_o set.
// Each byte goes from the front end into the two-entry queue, then into the
// output register; throughput is one byte per cycle while out_stall_i is low.
// If the receiver stalls, the output register holds, the queue fills, and
// in_stall_o rises once both queue entries are taken.
// Reset clears the configuration, the key position, the queue pointers and
// the output valid flag; nothing is pending, so input is taken at once.

module vigenere_stream_cipher (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     text_byte_i,
  input  logic                           text_last_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     cipher_byte_o,
  output logic                           cipher_last_o,
  output logic                           key_error_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [vsc_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [vsc_pkg::APB_DATA_W-1:0] pwdata,
  output logic [vsc_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import vsc_pkg::*;

  logic                 mode_q;
  logic [KEY_LEN_W-1:0] key_len_q;
  logic [63:0]          key_a_q;
  logic [63:0]          key_b_q;
  logic [63:0]          key_c_q;
  logic [63:0]          key_d_q;
  logic                 wr_en;
  vsc_reg_e             reg_idx;
  vsc_cfg_t             cfg;
  vsc_item_t            push_item;
  vsc_item_t            pop_item;
  logic                 push;
  logic                 pop;
  logic                 full;
  logic                 empty;

  // Configuration registers.
  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = vsc_reg_e'(paddr[APB_ADDR_W-1:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= 1'b0;
      key_len_q <= '0;
      key_a_q   <= '0;
      key_b_q   <= '0;
      key_c_q   <= '0;
      key_d_q   <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_CIPHER_MODE: mode_q    <= pwdata[0];
        REG_KEY_LENGTH:  key_len_q <= pwdata[KEY_LEN_W-1:0];
        REG_KEY_BYTES_A: key_a_q   <= pwdata;
        REG_KEY_BYTES_B: key_b_q   <= pwdata;
        REG_KEY_BYTES_C: key_c_q   <= pwdata;
        REG_KEY_BYTES_D: key_d_q   <= pwdata;
        default: ;
      endcase
    end
  end

  // Read-back decoder.
  always_comb begin
    unique case (reg_idx)
      REG_CIPHER_MODE: prdata = {{(APB_DATA_W-1){1'b0}}, mode_q};
      REG_KEY_LENGTH:  prdata = {{(APB_DATA_W-KEY_LEN_W){1'b0}}, key_len_q};
      REG_KEY_BYTES_A: prdata = key_a_q;
      REG_KEY_BYTES_B: prdata = key_b_q;
      REG_KEY_BYTES_C: prdata = key_c_q;
      REG_KEY_BYTES_D: prdata = key_d_q;
      default:         prdata = '0;
    endcase
  end

  assign cfg.mode       = mode_q;
  assign cfg.key_length = key_len_q;
  assign cfg.key_bytes  = {key_d_q, key_c_q, key_b_q, key_a_q};

  vsc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .text_byte_i (text_byte_i),
    .text_last_i (text_last_i),
    .cfg_i       (cfg),
    .full_i      (full),
    .push_o      (push),
    .push_item_o (push_item)
  );

  vsc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .pop_item_o  (pop_item),
    .full_o      (full),
    .empty_o     (empty)
  );

  vsc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .item_i        (pop_item),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .cipher_byte_o (cipher_byte_o),
    .cipher_last_o (cipher_last_o),
    .key_error_o   (key_error_o)
  );

endmodule
